@@ sv/sipc_pkg.sv @@
// ----------------------------------------------------------------------------
// sipc_pkg
// Types and constants shared by the scanline irq prescaled counter modules.
// ----------------------------------------------------------------------------
package sipc_pkg;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_CPU   = 2'd1,
        FUNC_PPU   = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        SRC_CPU   = 2'd0,
        SRC_A12   = 2'd1,
        SRC_NONE2 = 2'd2,
        SRC_NONE3 = 2'd3
    } clk_src_t;

    localparam logic [15:0] ADDR_MASK       = 16'hF007;
    localparam logic [15:0] REG_IRQ_CTRL    = 16'hC000;
    localparam logic [15:0] REG_MODE        = 16'hC001;
    localparam logic [15:0] REG_IRQ_OFF     = 16'hC002;
    localparam logic [15:0] REG_IRQ_ON      = 16'hC003;
    localparam logic [15:0] REG_PRESCALE    = 16'hC004;
    localparam logic [15:0] REG_COUNTER     = 16'hC005;
    localparam logic [15:0] REG_KEY         = 16'hC006;
    localparam logic [15:0] REG_ODD_WORD    = 16'hC007;

    localparam int unsigned A12_BIT         = 12;
    localparam logic [7:0]  COUNT_TOP       = 8'hFF;
    localparam logic [2:0]  SHORT_TOP       = 3'h7;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] access_address;
        logic [7:0]  write_data;
    } item_t;

    typedef struct packed {
        logic       irq_request;
        logic [7:0] counter_now;
        logic [7:0] prescaler_now;
    } result_t;

    // counting mode bits seen by the tick logic
    typedef struct packed {
        logic short_prescale;
        logic count_down_on;
        logic count_up_on;
    } ctrl_t;

endpackage

@@ sv/sipc_tick.sv @@
// ----------------------------------------------------------------------------
// sipc_tick
// One prescaler clock: advances the prescaler and, when it reaches its top,
// steps the up/down counter, flagging a reload when the counter wraps.
// ----------------------------------------------------------------------------
module sipc_tick (
    input  sipc_pkg::ctrl_t ctrl,
    input  logic [7:0]      prescale,
    input  logic [7:0]      count,
    output logic [7:0]      prescale_out,
    output logic [7:0]      count_out,
    output logic            reload
);

    logic [2:0] low_inc;
    logic [7:0] full_inc;
    logic [7:0] count_dec;
    logic [7:0] count_inc;
    logic       count_tick;

    assign low_inc   = prescale[2:0] + 3'd1;
    assign full_inc  = prescale + 8'd1;
    assign count_dec = count - 8'd1;
    assign count_inc = count + 8'd1;

    always_comb
    begin
        if (ctrl.short_prescale)
        begin
            prescale_out = {prescale[7:3], low_inc};
            count_tick   = (low_inc == sipc_pkg::SHORT_TOP);
        end
        else
        begin
            prescale_out = full_inc;
            count_tick   = (full_inc == sipc_pkg::COUNT_TOP);
        end

        count_out = count;
        reload    = 1'b0;
        if (count_tick)
        begin
            if (ctrl.count_down_on && !ctrl.count_up_on)
            begin
                if (count_dec == 8'd0)
                begin
                    count_out = sipc_pkg::COUNT_TOP;
                    reload    = 1'b1;
                end
                else
                begin
                    count_out = count_dec;
                end
            end
            else if (ctrl.count_up_on && !ctrl.count_down_on)
            begin
                if (count_inc == sipc_pkg::COUNT_TOP)
                begin
                    count_out = 8'd0;
                    reload    = 1'b1;
                end
                else
                begin
                    count_out = count_inc;
                end
            end
        end
    end

endmodule

@@ sv/sipc_engine.sv @@
// ----------------------------------------------------------------------------
// sipc_engine
// Holds the irq counter state, decodes register writes and clock events of
// one request and gives the result that follows from it.
// ----------------------------------------------------------------------------
module sipc_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  sipc_pkg::item_t   item,
    output sipc_pkg::result_t result
);

    logic [7:0]          prescale_reg,  prescale_next;
    logic [7:0]          count_reg,     count_next;
    logic [7:0]          key_reg,       key_next;
    logic                irq_en_reg,    irq_en_next;
    logic                pending_reg,   pending_next;
    sipc_pkg::ctrl_t     ctrl_reg,      ctrl_next;
    sipc_pkg::clk_src_t  src_reg,       src_next;
    logic                a12_reg,       a12_next;

    logic                tick;
    logic                level;
    logic [7:0]          tick_prescale;
    logic [7:0]          tick_count;
    logic                tick_reload;

    sipc_tick u_tick (
        .ctrl         (ctrl_reg),
        .prescale     (prescale_reg),
        .count        (count_reg),
        .prescale_out (tick_prescale),
        .count_out    (tick_count),
        .reload       (tick_reload)
    );

    assign level = item.access_address[sipc_pkg::A12_BIT];

    always_comb
    begin
        prescale_next = prescale_reg;
        count_next    = count_reg;
        key_next      = key_reg;
        irq_en_next   = irq_en_reg;
        pending_next  = pending_reg;
        ctrl_next     = ctrl_reg;
        src_next      = src_reg;
        a12_next      = a12_reg;
        tick          = 1'b0;

        if (fire)
        begin
            case (sipc_pkg::func_t'(item.func))
                sipc_pkg::FUNC_WRITE:
                begin
                    // odd mode registers have no effect and are not kept
                    unique case (item.access_address & sipc_pkg::ADDR_MASK)
                        sipc_pkg::REG_IRQ_CTRL:
                        begin
                            irq_en_next = item.write_data[0];
                            if (!item.write_data[0])
                            begin
                                pending_next = 1'b0;
                            end
                        end
                        sipc_pkg::REG_MODE:
                        begin
                            ctrl_next.count_down_on  = item.write_data[7];
                            ctrl_next.count_up_on    = item.write_data[6];
                            ctrl_next.short_prescale = item.write_data[2];
                            src_next = sipc_pkg::clk_src_t'(item.write_data[1:0]);
                        end
                        sipc_pkg::REG_IRQ_OFF:
                        begin
                            irq_en_next  = 1'b0;
                            pending_next = 1'b0;
                        end
                        sipc_pkg::REG_IRQ_ON:
                        begin
                            irq_en_next = 1'b1;
                        end
                        sipc_pkg::REG_PRESCALE:
                        begin
                            prescale_next = item.write_data ^ key_reg;
                        end
                        sipc_pkg::REG_COUNTER:
                        begin
                            count_next = item.write_data ^ key_reg;
                        end
                        sipc_pkg::REG_KEY:
                        begin
                            key_next = item.write_data;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                sipc_pkg::FUNC_CPU:
                begin
                    tick = (src_reg == sipc_pkg::SRC_CPU);
                end
                sipc_pkg::FUNC_PPU:
                begin
                    if (src_reg == sipc_pkg::SRC_A12)
                    begin
                        a12_next = level;
                        tick     = level && !a12_reg;
                    end
                end
                default:
                begin
                end
            endcase

            if (tick)
            begin
                prescale_next = tick_prescale;
                count_next    = tick_count;
                if (tick_reload && irq_en_reg)
                begin
                    pending_next = 1'b1;
                end
            end
        end
    end

    assign result.irq_request   = pending_next;
    assign result.counter_now   = count_next;
    assign result.prescaler_now = prescale_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= 8'd0;
            count_reg    <= 8'd0;
            key_reg      <= 8'd0;
            irq_en_reg   <= 1'b0;
            pending_reg  <= 1'b0;
            ctrl_reg     <= '0;
            src_reg      <= sipc_pkg::SRC_CPU;
            a12_reg      <= 1'b0;
        end
        else
        begin
            prescale_reg <= prescale_next;
            count_reg    <= count_next;
            key_reg      <= key_next;
            irq_en_reg   <= irq_en_next;
            pending_reg  <= pending_next;
            ctrl_reg     <= ctrl_next;
            src_reg      <= src_next;
            a12_reg      <= a12_next;
        end
    end

endmodule

@@ sv/scanline_irq_prescaled_counter.sv @@
// ----------------------------------------------------------------------------
// scanline_irq_prescaled_counter
// Mapper irq counter with prescaler, key-xored loads and up/down counting.
// ----------------------------------------------------------------------------
// Takes one request per clock while item_stall is low and gives exactly one
// result for each. A request passes through the input register, then the
// result register. The state update for a request happens between those
// registers, so a stall on the result side holds both stages and raises
// item_stall only once the input register is also full.
module scanline_irq_prescaled_counter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  sipc_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output sipc_pkg::result_t result
);

    logic              in_valid_reg;
    sipc_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    sipc_pkg::result_t out_reg;

    logic              out_free;
    logic              fire;
    sipc_pkg::result_t engine_result;

    assign out_free   = !out_valid_reg || !result_stall;
    assign fire       = in_valid_reg && out_free;
    assign item_stall = in_valid_reg && !out_free;

    sipc_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .result (engine_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!item_stall)
            begin
                in_valid_reg <= item_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
        begin
            in_item_reg <= item;
        end
        if (fire)
        begin
            out_reg <= engine_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scanline irq prescaled counter. A short table of
// hand-picked requests comes first, then random requests biased toward
// prescaler wraps and counter reloads. Every result is checked field by field
// against a typed row's value or a cycle-free model. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned RANDOM_ITEMS = 1750;
    localparam int unsigned QUIET_ITEMS  = 200;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct packed {
        sipc_pkg::item_t   req;
        logic              typed;
        sipc_pkg::result_t want;
    } row_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    sipc_pkg::item_t   item         = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    sipc_pkg::result_t result;

    // model of the counter state
    logic [7:0]          m_prescale;
    logic [7:0]          m_count;
    logic [7:0]          m_key;
    logic                m_irq_en;
    logic                m_irq_pend;
    logic                m_down;
    logic                m_up;
    logic                m_short;
    sipc_pkg::clk_src_t  m_src;
    logic                m_odd_bit;
    logic [7:0]          m_odd_word;
    logic                m_a12;

    sipc_pkg::result_t awaited_status[$];
    row_t              directed_rows[$];
    sipc_pkg::result_t modeled;
    sipc_pkg::result_t oldest;
    logic              row_typed = 1'b0;
    sipc_pkg::result_t row_want  = '0;
    bit                quiet     = 1'b0;
    int unsigned       stall_left = 0;
    int unsigned       cycle_count = 0;
    int unsigned       error_count = 0;
    int unsigned       checked_count = 0;
    int unsigned       reload_count = 0;
    int unsigned       irq_raise_count = 0;
    int unsigned       func_count[4] = '{0, 0, 0, 0};

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    scanline_irq_prescaled_counter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    function void clear_model();
        m_prescale = '0;
        m_count    = '0;
        m_key      = '0;
        m_irq_en   = 1'b0;
        m_irq_pend = 1'b0;
        m_down     = 1'b0;
        m_up       = 1'b0;
        m_short    = 1'b0;
        m_src      = sipc_pkg::SRC_CPU;
        m_odd_bit  = 1'b0;
        m_odd_word = '0;
        m_a12      = 1'b0;
    endfunction

    function void bump_event_count();
        logic reload;
        reload = 1'b0;
        // both directions or none: counter holds
        if (!(m_down && m_up))
        begin
            if (m_down)
            begin
                m_count = m_count - 8'd1;
                if (m_count == 8'd0)
                begin
                    m_count = sipc_pkg::COUNT_TOP;
                    reload  = 1'b1;
                end
            end
            else if (m_up)
            begin
                m_count = m_count + 8'd1;
                if (m_count == sipc_pkg::COUNT_TOP)
                begin
                    m_count = 8'd0;
                    reload  = 1'b1;
                end
            end
        end
        if (reload)
        begin
            reload_count++;
            if (m_irq_en && !m_irq_pend)
                irq_raise_count++;
            if (m_irq_en)
                m_irq_pend = 1'b1;
        end
    endfunction

    function void bump_prescale();
        if (m_short)
        begin
            // upper five bits are kept in the short mode
            m_prescale[2:0] = m_prescale[2:0] + 3'd1;
            if (m_prescale[2:0] == sipc_pkg::SHORT_TOP)
                bump_event_count();
        end
        else
        begin
            m_prescale = m_prescale + 8'd1;
            if (m_prescale == sipc_pkg::COUNT_TOP)
                bump_event_count();
        end
    endfunction

    function sipc_pkg::result_t irq_counter_step(input sipc_pkg::item_t req);
        logic              level;
        sipc_pkg::result_t r;
        func_count[req.func]++;
        case (req.func)
            sipc_pkg::FUNC_WRITE:
            begin
                case (req.access_address & sipc_pkg::ADDR_MASK)
                    sipc_pkg::REG_IRQ_CTRL:
                    begin
                        m_irq_en = req.write_data[0];
                        if (!m_irq_en)
                            m_irq_pend = 1'b0;
                    end
                    sipc_pkg::REG_MODE:
                    begin
                        m_down    = req.write_data[7];
                        m_up      = req.write_data[6];
                        m_odd_bit = req.write_data[3];
                        m_short   = req.write_data[2];
                        m_src     = sipc_pkg::clk_src_t'(req.write_data[1:0]);
                    end
                    sipc_pkg::REG_IRQ_OFF:
                    begin
                        m_irq_en   = 1'b0;
                        m_irq_pend = 1'b0;
                    end
                    sipc_pkg::REG_IRQ_ON:   m_irq_en   = 1'b1;
                    sipc_pkg::REG_PRESCALE: m_prescale = req.write_data ^ m_key;
                    sipc_pkg::REG_COUNTER:  m_count    = req.write_data ^ m_key;
                    sipc_pkg::REG_KEY:      m_key      = req.write_data;
                    sipc_pkg::REG_ODD_WORD: m_odd_word = req.write_data;
                    default: ;
                endcase
            end
            sipc_pkg::FUNC_CPU:
            begin
                if (m_src == sipc_pkg::SRC_CPU)
                    bump_prescale();
            end
            sipc_pkg::FUNC_PPU:
            begin
                // a12 level is only tracked while a12 is the source
                if (m_src == sipc_pkg::SRC_A12)
                begin
                    level = req.access_address[sipc_pkg::A12_BIT];
                    if (level && !m_a12)
                    begin
                        m_a12 = level;
                        bump_prescale();
                    end
                    m_a12 = level;
                end
            end
            default: ;
        endcase
        r.irq_request   = m_irq_pend;
        r.counter_now   = m_count;
        r.prescaler_now = m_prescale;
        return r;
    endfunction

    function automatic sipc_pkg::item_t random_request();
        sipc_pkg::item_t r;
        int unsigned     pick;
        logic [2:0]      reg_sel;
        logic [7:0]      target;
        pick             = $urandom_range(99);
        r.func           = sipc_pkg::FUNC_WRITE;
        r.access_address = 16'($urandom_range(16'hFFFF));
        r.write_data     = 8'($urandom_range(8'hFF));
        if (pick < 4)
            r.func = sipc_pkg::FUNC_NONE;
        else if (pick < 28 && pick >= 10)
        begin
            reg_sel          = 3'($urandom_range(7));
            r.access_address = {4'hC, 9'($urandom_range(9'h1FF)), reg_sel};
            case ({13'd0, reg_sel} | sipc_pkg::REG_IRQ_CTRL)
                sipc_pkg::REG_MODE:
                begin
                    // keep the clock source live most of the time
                    if ($urandom_range(3) != 0)
                        r.write_data[1] = 1'b0;
                end
                sipc_pkg::REG_PRESCALE:
                begin
                    if ($urandom_range(1) == 0)
                    begin
                        target       = $urandom_range(1) ? 8'hFD
                                                         : {5'($urandom_range(31)), 3'd5};
                        r.write_data = target ^ m_key;
                    end
                end
                sipc_pkg::REG_COUNTER:
                begin
                    // land near a reload point
                    if ($urandom_range(1) == 0)
                    begin
                        case ($urandom_range(3))
                            0:       target = 8'h01;
                            1:       target = 8'h02;
                            2:       target = 8'hFD;
                            default: target = 8'hFE;
                        endcase
                        r.write_data = target ^ m_key;
                    end
                end
                default: ;
            endcase
        end
        else if (pick >= 28 && pick < 64)
            r.func = sipc_pkg::FUNC_CPU;
        else if (pick >= 64)
            r.func = sipc_pkg::FUNC_PPU;
        return r;
    endfunction

    task automatic add_row(input sipc_pkg::func_t f, input logic [15:0] addr,
                           input logic [7:0] data, input logic typed, input logic irq,
                           input logic [7:0] cnt, input logic [7:0] pre);
        row_t row;
        row.req.func           = f;
        row.req.access_address = addr;
        row.req.write_data     = data;
        row.typed              = typed;
        row.want.irq_request   = irq;
        row.want.counter_now   = cnt;
        row.want.prescaler_now = pre;
        directed_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        error_count++;
        $display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h",
                 cycle_count, what, want, got);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input sipc_pkg::item_t req, input logic typed,
                                input sipc_pkg::result_t want);
        item       <= req;
        item_valid <= 1'b1;
        row_typed   = typed;
        row_want    = want;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic hold_off(input int unsigned cycles);
        item_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic random_gap();
        if (!quiet && $urandom_range(7) == 0)
            hold_off($urandom_range(1, 13));
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_status.size());
            $display("scanline_irq_prescaled_counter regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
        begin
            modeled = irq_counter_step(item);
            awaited_status.push_back(row_typed ? row_want : modeled);
        end
        if (rst_n && result_valid && !result_stall)
        begin
            if (awaited_status.size() == 0)
                report_mismatch("result with nothing awaited, counter", 8'h00,
                                result.counter_now);
            else
            begin
                oldest = awaited_status.pop_front();
                checked_count++;
                if (result.irq_request !== oldest.irq_request)
                    report_mismatch("irq_request", {7'd0, oldest.irq_request},
                                    {7'd0, result.irq_request});
                if (result.counter_now !== oldest.counter_now)
                    report_mismatch("counter_now", oldest.counter_now, result.counter_now);
                if (result.prescaler_now !== oldest.prescaler_now)
                    report_mismatch("prescaler_now", oldest.prescaler_now,
                                    result.prescaler_now);
            end
        end
    end

    // result side: random stall bursts, no new burst once the run goes quiet
    always @(negedge clk)
    begin
        if (stall_left == 0 && !quiet && rst_n && $urandom_range(9) == 0)
            stall_left = $urandom_range(1, 13);
        if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else
            result_stall <= 1'b0;
    end

    initial
    begin
        row_t              row;
        sipc_pkg::result_t none;
        int unsigned       i;
        none = '0;
        clear_model();

        add_row(sipc_pkg::FUNC_NONE,  16'hFFFF, 8'hFF, 1'b1, 1'b0, 8'h00, 8'h00);
        add_row(sipc_pkg::FUNC_CPU,   16'h0000, 8'h00, 1'b1, 1'b0, 8'h00, 8'h01);
        add_row(sipc_pkg::FUNC_WRITE, sipc_pkg::REG_KEY,
                8'hFF, 1'b1, 1'b0, 8'h00, 8'h01);
        add_row(sipc_pkg::FUNC_WRITE, sipc_pkg::REG_PRESCALE,
                8'h01, 1'b1, 1'b0, 8'h00, 8'hFE);
        add_row(sipc_pkg::FUNC_WRITE, sipc_pkg::REG_COUNTER,
                8'hFE, 1'b1, 1'b0, 8'h01, 8'hFE);
        add_row(sipc_pkg::FUNC_WRITE, sipc_pkg::REG_MODE,
                8'h80, 1'b1, 1'b0, 8'h01, 8'hFE);
        add_row(sipc_pkg::FUNC_WRITE, sipc_pkg::REG_IRQ_ON,
                8'h00, 1'b1, 1'b0, 8'h01, 8'hFE);
        // down count hits zero and reloads
        add_row(sipc_pkg::FUNC_CPU,   16'h0000, 8'h00, 1'b1, 1'b1, 8'hFF, 8'hFF);
        add_row(sipc_pkg::FUNC_CPU,   16'hFFFF, 8'hFF, 1'b1, 1'b1, 8'hFF, 8'h00);
        add_row(sipc_pkg::FUNC_WRITE, sipc_pkg::REG_IRQ_CTRL,
                8'hFE, 1'b1, 1'b0, 8'hFF, 8'h00);
        // mode through an aliased address: up, short prescaler, a12 source
        add_row(sipc_pkg::FUNC_WRITE, 16'hCFF9, 8'h45, 1'b0, 1'b0, 8'h00, 8'h00);
        add_row(sipc_pkg::FUNC_PPU,   16'h1000, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
        add_row(sipc_pkg::FUNC_PPU,   16'hEFFF, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00);
        add_row(sipc_pkg::FUNC_CPU,   16'h0000, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
        add_row(sipc_pkg::FUNC_WRITE, sipc_pkg::REG_KEY,
                8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
        add_row(sipc_pkg::FUNC_WRITE, sipc_pkg::REG_PRESCALE,
                8'h06, 1'b0, 1'b0, 8'h00, 8'h00);
        add_row(sipc_pkg::FUNC_WRITE, sipc_pkg::REG_COUNTER,
                8'hFE, 1'b0, 1'b0, 8'h00, 8'h00);
        add_row(sipc_pkg::FUNC_WRITE, sipc_pkg::REG_IRQ_ON,
                8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
        add_row(sipc_pkg::FUNC_PPU,   16'hFFFF, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
        add_row(sipc_pkg::FUNC_WRITE, sipc_pkg::REG_IRQ_OFF,
                8'hFF, 1'b0, 1'b0, 8'h00, 8'h00);
        // both directions set: the wrap leaves the counter alone
        add_row(sipc_pkg::FUNC_WRITE, sipc_pkg::REG_MODE,
                8'hC0, 1'b0, 1'b0, 8'h00, 8'h00);
        add_row(sipc_pkg::FUNC_WRITE, sipc_pkg::REG_PRESCALE,
                8'hFE, 1'b0, 1'b0, 8'h00, 8'h00);
        add_row(sipc_pkg::FUNC_CPU,   16'h0000, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
        add_row(sipc_pkg::FUNC_WRITE, sipc_pkg::REG_MODE,
                8'hC2, 1'b0, 1'b0, 8'h00, 8'h00);
        add_row(sipc_pkg::FUNC_PPU,   16'h1000, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00);
        add_row(sipc_pkg::FUNC_WRITE, sipc_pkg::REG_ODD_WORD,
                8'hA5, 1'b0, 1'b0, 8'h00, 8'h00);
        add_row(sipc_pkg::FUNC_WRITE, sipc_pkg::REG_MODE,
                8'h08, 1'b0, 1'b0, 8'h00, 8'h00);
        add_row(sipc_pkg::FUNC_WRITE, 16'hD001, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            random_gap();
            send_request(row.req, row.typed, row.want);
        end

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
            begin
                // let the pipeline run dry once
                hold_off(1);
                while (awaited_status.size() != 0)
                    @(negedge clk);
            end
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            random_gap();
            send_request(random_request(), 1'b0, none);
        end

        hold_off(1);
        while (awaited_status.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d requests: %0d writes, %0d cpu ticks, %0d ppu updates,",
                 func_count[0] + func_count[1] + func_count[2] + func_count[3],
                 func_count[0], func_count[1], func_count[2]);
        $display("  %0d idle codes; checked %0d results, %0d reloads, %0d irq raises",
                 func_count[3], checked_count, reload_count, irq_raise_count);
        if (error_count == 0)
            $display("scanline_irq_prescaled_counter regression: pass");
        else
            $display("scanline_irq_prescaled_counter regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
sv/sipc_pkg.sv
sv/sipc_tick.sv
sv/sipc_engine.sv
sv/scanline_irq_prescaled_counter.sv
bench/tb_top.sv
